/* design/tfm_pkg.sv */
// Shared types and constants of the topic filter match table.
// Used by every module of the block but tfm_ram; depends on nothing.
package tfm_pkg;

  localparam int NUM_FILTERS_DEF = 8;
  localparam int FILTER_LEN_DEF  = 64;
  localparam int PADDR_W         = 3;

  localparam logic [1:0] KIND_FWRITE = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TOPIC  = 2'd2;

  localparam logic [1:0] MODE_CMP  = 2'd0;
  localparam logic [1:0] MODE_PLUS = 2'd1;
  localparam logic [1:0] MODE_ALL  = 2'd2;
  localparam logic [1:0] MODE_FAIL = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_TRUNC    = 2'd2;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic REG_DEFAULT_EN = 1'b0;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] match_mask;
    logic       use_default;
    logic [1:0] status;
    logic       for_topic;
  } result_t;

endpackage

/* design/tfm_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Stands alone; no package needed.
module tfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/tfm_cfg.sv */
// APB-style configuration register file holding the default enable.
// Uses tfm_pkg for the register index and address width.
module tfm_cfg import tfm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               default_enabled
);

  logic default_en_r;
  logic default_en_nxt;
  logic hit_default;

  assign hit_default = (paddr[PADDR_W-1] == REG_DEFAULT_EN);

  always_comb begin
    default_en_nxt = default_en_r;
    if (psel && penable && pwrite && hit_default) begin
      default_en_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_en_r <= 1'b0;
    end else begin
      default_en_r <= default_en_nxt;
    end
  end

  assign prdata          = hit_default ? {31'd0, default_en_r} : 32'd0;
  assign pready          = 1'b1;
  assign default_enabled = default_en_r;

endmodule

/* design/tfm_engine.sv */
// Sequencer of the match table: per-slot match state, filter writes and the
// slot sweep over the filter character RAM. Uses tfm_pkg; drives tfm_ram.
module tfm_engine import tfm_pkg::*; #(
  parameter int NUM_FILTERS = NUM_FILTERS_DEF,
  parameter int FILTER_LEN  = FILTER_LEN_DEF,
  localparam int NS  = (NUM_FILTERS < 8) ? NUM_FILTERS : 8,
  localparam int AW  = $clog2(NS * FILTER_LEN)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  item_t         in_item,
  input  logic          default_enabled,
  output logic          out_valid,
  input  logic          out_stall,
  output result_t       out_res,
  output logic          ram_we,
  output logic [AW-1:0] ram_addr,
  output logic [7:0]    ram_wdata,
  input  logic [7:0]    ram_rdata
);

  localparam int SW  = (NS > 1) ? $clog2(NS) : 1;
  localparam int IW  = $clog2(FILTER_LEN);
  localparam int TCW = $clog2(FILTER_LEN + 1);

  localparam logic [IW-1:0]  LEN_LIM   = IW'(FILTER_LEN - 1);
  localparam logic [TCW-1:0] TC_LIM    = TCW'(FILTER_LEN - 1);
  localparam logic [TCW-1:0] TC_FULL   = TCW'(FILTER_LEN);
  localparam logic [SW-1:0]  LAST_SLOT = SW'(NS - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_WR   = 4'd1;
  localparam logic [3:0] ST_CMP  = 4'd2;
  localparam logic [3:0] ST_CMPD = 4'd3;
  localparam logic [3:0] ST_END  = 4'd4;
  localparam logic [3:0] ST_E1   = 4'd5;
  localparam logic [3:0] ST_E2   = 4'd6;
  localparam logic [3:0] ST_E3   = 4'd7;
  localparam logic [3:0] ST_PUSH = 4'd8;

  logic [3:0]     state_r, state_nxt;
  logic [SW-1:0]  cur_r, cur_nxt;
  logic [TCW-1:0] tc_r, tc_nxt;
  logic           out_valid_r, out_valid_nxt;
  result_t        out_res_r, out_res_nxt;
  result_t        res_r, res_nxt;
  logic [1:0]     kind_r, kind_nxt;
  logic [7:0]     ch_r, ch_nxt;
  logic           last_r, last_nxt;
  logic [IW-1:0]  q_r, q_nxt;
  logic [NS-1:0]  mask_r, mask_nxt;

  logic [IW-1:0]  len_r   [NS];
  logic [IW-1:0]  len_nxt [NS];
  logic [IW-1:0]  pos_r   [NS];
  logic [IW-1:0]  pos_nxt [NS];
  logic [1:0]     mode_r  [NS];
  logic [1:0]     mode_nxt[NS];
  logic           valid_r [NS];
  logic           valid_nxt[NS];
  logic           ovf_r   [NS];
  logic           ovf_nxt [NS];

  logic [IW-1:0]  cur_len;
  logic [IW-1:0]  cur_pos;
  logic [1:0]     cur_mode;
  logic [IW-1:0]  wr_len;
  logic           wr_ovf;
  logic [IW-1:0]  q_inc;
  logic           accept;
  logic           slot_ok;
  logic           step_cmp;
  logic           step_end;
  logic           hit;
  logic           do_eval;

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s, input logic [IW-1:0] i);
    return AW'(AW'(s) * AW'(FILTER_LEN) + AW'(i));
  endfunction

  assign cur_len  = len_r[cur_r];
  assign cur_pos  = pos_r[cur_r];
  assign cur_mode = mode_r[cur_r];
  assign wr_len   = valid_r[cur_r] ? '0 : cur_len;
  assign wr_ovf   = valid_r[cur_r] ? 1'b0 : ovf_r[cur_r];
  assign q_inc    = q_r + IW'(1);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign slot_ok  = ({1'b0, in_item.slot} < 4'(NS));

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    tc_nxt        = tc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    res_nxt       = res_r;
    kind_nxt      = kind_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    q_nxt         = q_r;
    mask_nxt      = mask_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    mode_nxt      = mode_r;
    valid_nxt     = valid_r;
    ovf_nxt       = ovf_r;
    ram_we        = 1'b0;
    ram_addr      = slot_addr(cur_r, cur_pos);
    ram_wdata     = ch_r;
    step_cmp      = 1'b0;
    step_end      = 1'b0;
    hit           = 1'b0;
    do_eval       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_item.kind;
          ch_nxt   = in_item.ch;
          last_nxt = in_item.last;
          if ((in_item.kind == KIND_FWRITE || in_item.kind == KIND_REMOVE) && slot_ok) begin
            cur_nxt   = in_item.slot[SW-1:0];
            state_nxt = ST_WR;
          end else if (in_item.kind == KIND_TOPIC) begin
            mask_nxt = '0;
            cur_nxt  = '0;
            if (tc_r == '0) begin
              for (int i = 0; i < NS; i++) begin
                pos_nxt[i]  = '0;
                mode_nxt[i] = MODE_CMP;
              end
            end
            if (tc_r < TC_LIM) begin
              tc_nxt    = tc_r + TCW'(1);
              state_nxt = ST_CMP;
            end else begin
              tc_nxt = TC_FULL;
              if (in_item.last) begin
                state_nxt = ST_END;
              end
            end
          end
        end
      end
      ST_WR: begin
        mode_nxt[cur_r] = MODE_FAIL;
        res_nxt         = '0;
        if (kind_r == KIND_REMOVE) begin
          valid_nxt[cur_r] = 1'b0;
          len_nxt[cur_r]   = '0;
          ovf_nxt[cur_r]   = 1'b0;
          res_nxt.status   = STATUS_OK;
          state_nxt        = ST_PUSH;
        end else begin
          valid_nxt[cur_r] = 1'b0;
          len_nxt[cur_r]   = wr_len;
          ovf_nxt[cur_r]   = wr_ovf;
          if (wr_len < LEN_LIM) begin
            ram_we         = 1'b1;
            ram_addr       = slot_addr(cur_r, wr_len);
            len_nxt[cur_r] = wr_len + IW'(1);
          end else begin
            ovf_nxt[cur_r] = 1'b1;
          end
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else if (ovf_nxt[cur_r]) begin
            len_nxt[cur_r] = '0;
            ovf_nxt[cur_r] = 1'b0;
            res_nxt.status = STATUS_TOO_LONG;
            state_nxt      = ST_PUSH;
          end else begin
            valid_nxt[cur_r] = 1'b1;
            res_nxt.status   = STATUS_OK;
            state_nxt        = ST_PUSH;
          end
        end
      end
      ST_CMP: begin
        if (cur_mode == MODE_CMP || (cur_mode == MODE_PLUS && ch_r == CH_SLASH)) begin
          if (cur_pos >= cur_len) begin
            mode_nxt[cur_r] = MODE_FAIL;
            step_cmp        = 1'b1;
          end else begin
            mode_nxt[cur_r] = MODE_CMP;
            state_nxt       = ST_CMPD;
          end
        end else begin
          step_cmp = 1'b1;
        end
      end
      ST_CMPD: begin
        if (ram_rdata == CH_HASH) begin
          mode_nxt[cur_r] = MODE_ALL;
          step_cmp        = 1'b1;
        end else if (ram_rdata == CH_PLUS) begin
          pos_nxt[cur_r] = cur_pos + IW'(1);
          if (ch_r != CH_SLASH) begin
            mode_nxt[cur_r] = MODE_PLUS;
            step_cmp        = 1'b1;
          end else begin
            state_nxt = ST_CMP;
          end
        end else if (ram_rdata == ch_r) begin
          pos_nxt[cur_r]  = cur_pos + IW'(1);
          mode_nxt[cur_r] = MODE_CMP;
          step_cmp        = 1'b1;
        end else begin
          mode_nxt[cur_r] = MODE_FAIL;
          step_cmp        = 1'b1;
        end
      end
      ST_END: begin
        if (!valid_r[cur_r] || cur_mode == MODE_FAIL) begin
          step_end = 1'b1;
        end else if (cur_mode == MODE_ALL || cur_pos >= cur_len) begin
          hit      = 1'b1;
          step_end = 1'b1;
        end else begin
          q_nxt     = cur_pos;
          state_nxt = ST_E1;
        end
      end
      ST_E1: begin
        if (ram_rdata == CH_PLUS) begin
          q_nxt = q_inc;
          if (q_inc >= cur_len) begin
            hit      = 1'b1;
            step_end = 1'b1;
          end else begin
            ram_addr  = slot_addr(cur_r, q_inc);
            state_nxt = ST_E2;
          end
        end else begin
          do_eval = 1'b1;
        end
      end
      ST_E2: begin
        do_eval = 1'b1;
      end
      ST_E3: begin
        hit      = (ram_rdata == CH_HASH);
        step_end = 1'b1;
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_eval) begin
      if (ram_rdata == CH_HASH) begin
        hit      = 1'b1;
        step_end = 1'b1;
      end else if (ram_rdata == CH_SLASH && q_inc < cur_len) begin
        ram_addr  = slot_addr(cur_r, q_inc);
        state_nxt = ST_E3;
      end else begin
        step_end = 1'b1;
      end
    end

    if (step_cmp) begin
      if (cur_r == LAST_SLOT) begin
        cur_nxt   = '0;
        state_nxt = last_r ? ST_END : ST_IDLE;
      end else begin
        cur_nxt   = cur_r + SW'(1);
        state_nxt = ST_CMP;
      end
    end

    if (step_end) begin
      if (hit) begin
        mask_nxt[cur_r] = 1'b1;
      end
      if (cur_r == LAST_SLOT) begin
        res_nxt.match_mask  = 8'(mask_nxt);
        res_nxt.use_default = (mask_nxt == '0) && default_enabled;
        res_nxt.status      = (tc_r == TC_FULL) ? STATUS_TRUNC : STATUS_OK;
        res_nxt.for_topic   = 1'b1;
        tc_nxt              = '0;
        cur_nxt             = '0;
        state_nxt           = ST_PUSH;
      end else begin
        cur_nxt   = cur_r + SW'(1);
        state_nxt = ST_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      tc_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        len_r[i]   <= '0;
        pos_r[i]   <= '0;
        mode_r[i]  <= MODE_CMP;
        valid_r[i] <= 1'b0;
        ovf_r[i]   <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      tc_r        <= tc_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      mode_r      <= mode_nxt;
      valid_r     <= valid_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    res_r     <= res_nxt;
    kind_r    <= kind_nxt;
    ch_r      <= ch_nxt;
    last_r    <= last_nxt;
    q_r       <= q_nxt;
    mask_r    <= mask_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* design/topic_filter_match_table.sv */
// Topic filter match table: filters are stored in a character RAM and a
// topic is streamed against them one character at a time. A filter character
// write or a slot removal is applied in the write state; the ack of a
// removal or of a filter's last character goes via the push state to the
// output register. A topic character sweeps the slots in the compare state,
// with a compare-data state for a slot that reads a filter character; a '+'
// met on a '/' goes back to compare. The last character of a topic adds an
// end sweep through the end state and states E1 to E3, then the push state
// loads the output register. The filter RAM's single read port is visited
// one slot at a time. Filter characters are only read below a slot's stored
// length, so the RAM needs no clearing after reset. The output register lets
// the next item in while a result still waits to be taken.
module topic_filter_match_table import tfm_pkg::*; #(
  parameter int NUM_FILTERS = NUM_FILTERS_DEF,
  parameter int FILTER_LEN  = FILTER_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [2:0]         in_slot,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_match_mask,
  output logic               out_use_default,
  output logic [1:0]         out_status,
  output logic               out_for_topic,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NS    = (NUM_FILTERS < 8) ? NUM_FILTERS : 8;
  localparam int DEPTH = NS * FILTER_LEN;
  localparam int AW    = $clog2(DEPTH);

  item_t          item;
  result_t        res;
  logic           default_enabled;
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;

  assign item.kind = in_kind;
  assign item.slot = in_slot;
  assign item.ch   = in_ch;
  assign item.last = in_last;

  tfm_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .default_enabled (default_enabled)
  );

  tfm_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tfm_engine #(
    .NUM_FILTERS (NUM_FILTERS),
    .FILTER_LEN  (FILTER_LEN)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (item),
    .default_enabled (default_enabled),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_res         (res),
    .ram_we          (ram_we),
    .ram_addr        (ram_addr),
    .ram_wdata       (ram_wdata),
    .ram_rdata       (ram_rdata)
  );

  assign out_match_mask  = res.match_mask;
  assign out_use_default = res.use_default;
  assign out_status      = res.status;
  assign out_for_topic   = res.for_topic;

endmodule

/* design/tfm_checker.sv */
// Port-level checks of the topic filter match table and their bind.
// Uses tfm_pkg for the status codes.
module tfm_checker import tfm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_match_mask,
  input logic       out_use_default,
  input logic [1:0] out_status,
  input logic       out_for_topic
);

  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_for_topic |->
      out_match_mask == 8'd0 && !out_use_default && out_status != STATUS_TRUNC)
    else $error("filter ack carries topic fields");

  a_topic_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_for_topic |-> out_status != STATUS_TOO_LONG)
    else $error("topic result reports a rejected filter");

  a_default_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_use_default |-> out_match_mask == 8'd0 && out_for_topic)
    else $error("default flag raised with a nonzero mask");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_match_mask) && $stable(out_status) &&
      $stable(out_for_topic) && $stable(out_use_default))
    else $error("stalled result item changed");

endmodule

bind topic_filter_match_table tfm_checker u_tfm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_match_mask  (out_match_mask),
  .out_use_default (out_use_default),
  .out_status      (out_status),
  .out_for_topic   (out_for_topic)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of topic_filter_match_table: filter writes, removals and topics
// go in over the item channel while a filter table predictor builds the expected results.
// Depends on tfm_pkg and the topic_filter_match_table module only.
module tb;
  import tfm_pkg::*;

  localparam int NUM_SLOTS = NUM_FILTERS_DEF;
  localparam int FLT_LEN = FILTER_LEN_DEF;
  localparam int ITEMS_TOTAL = 1150;
  localparam int SETTLE_CYCLES = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_DEFAULT_EN = PADDR_W'(4 * int'(REG_DEFAULT_EN));

  typedef logic [7:0] chars_t[$];

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_kind;
  logic [2:0] in_slot;
  logic [7:0] in_ch;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_match_mask;
  logic out_use_default;
  logic [1:0] out_status;
  logic out_for_topic;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [7:0] flt_chars [NUM_SLOTS][FLT_LEN];
  logic [6:0] flt_len [NUM_SLOTS];
  logic flt_valid [NUM_SLOTS];
  logic flt_ovf [NUM_SLOTS];
  logic [6:0] mt_pos [NUM_SLOTS];
  logic [1:0] mt_mode [NUM_SLOTS];
  logic [6:0] topic_cnt;
  logic dflt_en;
  result_t expected_results[$];

  int errors = 0;
  int items_done = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_style = 0;
  int style_left = 0;
  int style_phase = 0;
  longint cycle_count = 0;

  topic_filter_match_table u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_slot(in_slot),
    .in_ch(in_ch),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_match_mask(out_match_mask),
    .out_use_default(out_use_default),
    .out_status(out_status),
    .out_for_topic(out_for_topic),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%s mismatch, got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  // Applies one accepted item to the table copy; returns 1 when the item has a result.
  function automatic bit table_apply(input item_t it, output result_t r);
    int s;
    int i;
    int p;
    int len;
    bit done;
    logic [7:0] mask;
    r = '0;
    r.status = STATUS_OK;
    s = int'(it.slot);
    case (it.kind)
      KIND_FWRITE, KIND_REMOVE: begin
        mt_mode[s] = MODE_FAIL;
        if (it.kind == KIND_REMOVE || flt_valid[s]) begin
          flt_valid[s] = 1'b0;
          flt_len[s] = '0;
          flt_ovf[s] = 1'b0;
        end
        if (it.kind == KIND_FWRITE) begin
          if (int'(flt_len[s]) < FLT_LEN - 1) begin
            flt_chars[s][flt_len[s]] = it.ch;
            flt_len[s]++;
          end else begin
            flt_ovf[s] = 1'b1;
          end
          if (!it.last) return 1'b0;
          if (flt_ovf[s]) begin
            r.status = STATUS_TOO_LONG;
            flt_len[s] = '0;
            flt_ovf[s] = 1'b0;
          end else begin
            flt_valid[s] = 1'b1;
          end
        end
        return 1'b1;
      end
      KIND_TOPIC: begin
        if (topic_cnt == 0) begin
          for (i = 0; i < NUM_SLOTS; i++) begin
            mt_pos[i] = '0;
            mt_mode[i] = MODE_CMP;
          end
        end
        if (int'(topic_cnt) < FLT_LEN - 1) begin
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (mt_mode[i] == MODE_PLUS && it.ch == CH_SLASH) mt_mode[i] = MODE_CMP;
            if (mt_mode[i] == MODE_CMP) begin
              p = int'(mt_pos[i]);
              len = int'(flt_len[i]);
              done = 1'b0;
              while (!done) begin
                done = 1'b1;
                if (p >= len) begin
                  mt_mode[i] = MODE_FAIL;
                end else if (flt_chars[i][p] == CH_HASH) begin
                  mt_mode[i] = MODE_ALL;
                end else if (flt_chars[i][p] == CH_PLUS) begin
                  p++;
                  mt_pos[i] = 7'(p);
                  if (it.ch != CH_SLASH) mt_mode[i] = MODE_PLUS;
                  else done = 1'b0;
                end else if (flt_chars[i][p] == it.ch) begin
                  mt_pos[i] = 7'(p + 1);
                end else begin
                  mt_mode[i] = MODE_FAIL;
                end
              end
            end
          end
          topic_cnt++;
        end else begin
          topic_cnt = 7'(FLT_LEN);
        end
        if (!it.last) return 1'b0;
        mask = '0;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (flt_valid[i]) begin
            p = int'(mt_pos[i]);
            len = int'(flt_len[i]);
            if (mt_mode[i] == MODE_ALL) begin
              mask[i] = 1'b1;
            end else if (mt_mode[i] != MODE_FAIL) begin
              if (p < len && flt_chars[i][p] == CH_PLUS) p++;
              if (p >= len) mask[i] = 1'b1;
              else if (flt_chars[i][p] == CH_HASH) mask[i] = 1'b1;
              else if (flt_chars[i][p] == CH_SLASH && p + 1 < len &&
                       flt_chars[i][p + 1] == CH_HASH) mask[i] = 1'b1;
            end
          end
        end
        r.match_mask = mask;
        r.use_default = (mask == 0) && dflt_en;
        r.status = (int'(topic_cnt) >= FLT_LEN) ? STATUS_TRUNC : STATUS_OK;
        r.for_topic = 1'b1;
        topic_cnt = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_match_mask), 32'(0));
      end else begin
        want = expected_results.pop_front();
        if (out_match_mask !== want.match_mask)
          report_mismatch("match_mask", 32'(out_match_mask), 32'(want.match_mask));
        if (out_use_default !== want.use_default)
          report_mismatch("use_default", 32'(out_use_default), 32'(want.use_default));
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_for_topic !== want.for_topic)
          report_mismatch("for_topic", 32'(out_for_topic), 32'(want.for_topic));
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        if (style_left == 0) begin
          stall_style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 300);
          style_phase = 0;
        end
        style_left--;
        style_phase++;
        case (stall_style)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 99) < 30);
          2: out_stall = ((style_phase % 5) < 2);
          default: out_stall = ($urandom_range(0, 99) < 80);
        endcase
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [2:0] slot,
                           input logic [7:0] ch, input logic last);
    item_t it;
    result_t r;
    int gap;
    it.kind = kind;
    it.slot = slot;
    it.ch = ch;
    it.last = last;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_kind = kind;
    in_slot = slot;
    in_ch = ch;
    in_last = last;
    do @(posedge clk); while (in_stall);
    if (kind != KIND_UNUSED) items_done++;
    if (table_apply(it, r)) expected_results.push_back(r);
  endtask

  task automatic send_chars(input logic [1:0] kind, input logic [2:0] slot, input chars_t q);
    int i;
    for (i = 0; i < q.size(); i++) send_item(kind, slot, q[i], i == q.size() - 1);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_default_enable(input logic en);
    drain_results();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_DEFAULT_EN;
    pwdata = 32'(en);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    dflt_en = en;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(en)) report_mismatch("default_enabled readback", prdata, 32'(en));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic chars_t str_bytes(input string s);
    chars_t q;
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic chars_t repeat_char(input logic [7:0] c, input int n);
    chars_t q;
    repeat (n) q.push_back(c);
    return q;
  endfunction

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'h61 + 8'($urandom_range(0, 2));
    else if (r < 65) return CH_SLASH;
    else if (r < 75) return CH_PLUS;
    else if (r < 82) return CH_HASH;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic chars_t rand_text(input int n);
    chars_t q;
    repeat (n) q.push_back(rand_char());
    return q;
  endfunction

  task automatic test_directed();
    send_chars(KIND_FWRITE, 3'd0, str_bytes("a/b"));
    send_chars(KIND_FWRITE, 3'd1, str_bytes("a/+"));
    send_chars(KIND_FWRITE, 3'd2, str_bytes("a/#"));
    send_chars(KIND_FWRITE, 3'd3, str_bytes("#"));
    send_chars(KIND_FWRITE, 3'd4, str_bytes("+/+"));
    send_chars(KIND_FWRITE, 3'd5, str_bytes("+"));
    send_chars(KIND_FWRITE, 3'd6, repeat_char(8'h00, 1));
    send_chars(KIND_FWRITE, 3'd7, repeat_char(8'h78, FLT_LEN - 1));
    send_chars(KIND_TOPIC, 3'd0, str_bytes("a/b"));
    send_chars(KIND_TOPIC, 3'd7, str_bytes("a"));
    send_chars(KIND_TOPIC, 3'd2, str_bytes("a/"));
    send_chars(KIND_TOPIC, 3'd5, str_bytes("/"));
    send_chars(KIND_TOPIC, 3'd1, repeat_char(8'h00, 1));
    send_chars(KIND_TOPIC, 3'd3, repeat_char(8'h78, FLT_LEN - 1));
    send_chars(KIND_TOPIC, 3'd4, repeat_char(8'h78, FLT_LEN + 6));
    send_chars(KIND_TOPIC, 3'd6, '{8'hFF, CH_SLASH, 8'h80});
    send_chars(KIND_FWRITE, 3'd6, repeat_char(8'h79, FLT_LEN));
    send_item(KIND_REMOVE, 3'd0, 8'hFF, 1'b1);
    send_item(KIND_TOPIC, 3'd5, 8'h61, 1'b0);
    send_item(KIND_REMOVE, 3'd1, 8'h00, 1'b0);
    send_chars(KIND_TOPIC, 3'd2, str_bytes("/b"));
    send_item(KIND_UNUSED, 3'd7, 8'h5A, 1'b1);
    send_chars(KIND_FWRITE, 3'd5, str_bytes("b"));
    send_chars(KIND_TOPIC, 3'd0, str_bytes("b"));
    send_chars(KIND_TOPIC, 3'd0, str_bytes("a/b/c"));
  endtask

  task automatic test_default_delivery();
    set_default_enable(1'b1);
    send_chars(KIND_TOPIC, 3'd3, str_bytes("zz/q"));
    send_chars(KIND_FWRITE, 3'd3, str_bytes("zz/+"));
    send_chars(KIND_TOPIC, 3'd4, str_bytes("zz/q"));
    send_chars(KIND_TOPIC, 3'd7, str_bytes("q"));
    send_chars(KIND_TOPIC, 3'd1, repeat_char(CH_PLUS, 1));
  endtask

  task automatic test_random();
    int ph;
    int target;
    int op;
    int s;
    int k;
    int n;
    int i;
    logic [7:0] c;
    chars_t q;
    for (ph = 0; ph < 4; ph++) begin
      set_default_enable(ph % 2 == 0);
      target = items_done + (ITEMS_TOTAL - 60 - items_done) / (4 - ph);
      while (items_done < target) begin
        op = $urandom_range(0, 99);
        s = $urandom_range(0, NUM_SLOTS - 1);
        if (op < 22) begin
          send_chars(KIND_FWRITE, 3'(s), rand_text($urandom_range(1, 8)));
        end else if (op < 27) begin
          send_item(KIND_REMOVE, 3'(s), 8'($urandom), 1'($urandom));
        end else if (op < 70) begin
          q = {};
          if (!flt_valid[s]) begin
            q = rand_text($urandom_range(1, 8));
          end else begin
            for (i = 0; i < int'(flt_len[s]); i++) begin
              c = flt_chars[s][i];
              if (c == CH_PLUS) begin
                n = $urandom_range(0, 3);
                repeat (n) q.push_back(8'h61 + 8'($urandom_range(0, 2)));
              end else if (c == CH_HASH) begin
                if ($urandom_range(0, 1) == 1 && q.size() > 0 && q[$] == CH_SLASH)
                  void'(q.pop_back());
                else
                  q = {q, rand_text($urandom_range(0, 5))};
                break;
              end else begin
                q.push_back(c);
              end
            end
            if (q.size() > 0 && $urandom_range(0, 9) == 0)
              q[$urandom_range(0, q.size() - 1)] = rand_char();
            if (q.size() == 0) q.push_back(rand_char());
          end
          send_chars(KIND_TOPIC, 3'($urandom), q);
        end else if (op < 82) begin
          send_chars(KIND_TOPIC, 3'($urandom), rand_text($urandom_range(1, 10)));
        end else if (op < 88) begin
          q = rand_text($urandom_range(2, 8));
          k = $urandom_range(1, q.size() - 1);
          for (i = 0; i < k; i++) send_item(KIND_TOPIC, 3'($urandom), q[i], 1'b0);
          if ($urandom_range(0, 1) == 1)
            send_chars(KIND_FWRITE, 3'(s), rand_text($urandom_range(1, 4)));
          else
            send_item(KIND_REMOVE, 3'(s), 8'($urandom), 1'b1);
          for (i = k; i < q.size(); i++)
            send_item(KIND_TOPIC, 3'($urandom), q[i], i == q.size() - 1);
        end else if (op < 91) begin
          send_item(KIND_UNUSED, 3'($urandom), 8'($urandom), 1'($urandom));
        end else if (op < 94) begin
          n = $urandom_range(1, 3);
          repeat (n) send_item(KIND_FWRITE, 3'(s), rand_char(), 1'b0);
        end else if (op < 96) begin
          send_chars(KIND_FWRITE, 3'(s), rand_text($urandom_range(FLT_LEN - 4, FLT_LEN + 2)));
        end else if (op < 98) begin
          send_chars(KIND_TOPIC, 3'($urandom),
                     rand_text($urandom_range(FLT_LEN - 4, FLT_LEN + 6)));
        end else begin
          send_item(KIND_FWRITE, 3'(s), rand_char(), 1'b1);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (40) send_item(KIND_TOPIC, 3'($urandom), rand_char(), 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_FWRITE;
    in_slot = '0;
    in_ch = '0;
    in_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    dflt_en = 1'b0;
    topic_cnt = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      flt_len[i] = '0;
      flt_valid[i] = 1'b0;
      flt_ovf[i] = 1'b0;
      mt_pos[i] = '0;
      mt_mode[i] = MODE_CMP;
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_default_delivery();
    test_random();
    test_backpressure();
    drain_results();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
